### rtl/core/hxf_pkg.sv
// Package for the uppercase hex field formatter.
// Holds the descriptor type passed from the front to the back and the ASCII constants.
// No dependencies.
`default_nettype none

package hxf_pkg;

  localparam int unsigned PosW = 7;

  localparam logic [6:0] CharSpace = 7'h20;
  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharUpperA = 7'h41;

  // Character positions of one field: [0,b1) spaces, [b1,b2) minus, [b2,b3) zeros,
  // [b3,b4) digits, [b4,total) spaces.
  typedef struct packed {
    logic [63:0]     value;
    logic [PosW-1:0] b1;
    logic [PosW-1:0] b2;
    logic [PosW-1:0] b3;
    logic [PosW-1:0] b4;
    logic [PosW-1:0] total;
  } desc_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] r;
    if (nib < 4'd10) begin
      r = CharZero + {3'b000, nib};
    end else begin
      r = CharUpperA + {3'b000, nib} - 7'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hxf_fifo.sv
// Small first-word-fall-through queue of register entries.
// Used between front and back and as the result buffer; depends on nothing.
`default_nettype none

module hxf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hxf_front.sv
// Front of the formatter: classifies one word into a field layout descriptor.
// Depends on hxf_pkg.
`default_nettype none

module hxf_front #(
  parameter int unsigned MaxField = 40
) (
  input  wire logic              [63:0] value_i,
  input  wire logic              [5:0]  field_width_i,
  input  wire logic signed       [6:0]  precision_i,
  input  wire logic                     left_justify_i,
  input  wire logic                     zero_pad_i,
  input  wire logic                     sign_flag_i,
  output hxf_pkg::desc_t                desc_o,
  output logic                          nonempty_o
);

  localparam logic [5:0] MaxW = 6'(MaxField);

  logic [5:0] w, p;
  logic       has_prec;
  logic [3:0] hi;
  logic [4:0] len;
  logic signed [7:0] z, s;
  logic [6:0] zc, sc, b1, b2, b3, b4, total;

  assign w        = (field_width_i > MaxW) ? MaxW : field_width_i;
  assign has_prec = ~precision_i[6];
  assign p        = (precision_i[5:0] > MaxW) ? MaxW : precision_i[5:0];

  always_comb begin
    hi = '0;
    for (int i = 0; i < 16; i++) begin
      if (value_i[4*i +: 4] != 4'd0) begin
        hi = 4'(i);
      end
    end
    len = {1'b0, hi} + 5'd1;
    if (has_prec && (p == 6'd0) && (value_i == 64'd0)) begin
      len = 5'd0;
    end
  end

  always_comb begin
    z = 8'sd0;
    if (zero_pad_i && !left_justify_i && !has_prec) begin
      z = $signed({2'b00, w}) - $signed({3'b000, len});
    end
    if (has_prec && ({1'b0, len} < p)) begin
      z = $signed({2'b00, p}) - $signed({3'b000, len});
    end
    s  = $signed({2'b00, w}) - $signed({3'b000, len}) - z;
    zc = z[7] ? 7'd0 : z[6:0];
    sc = s[7] ? 7'd0 : s[6:0];
  end

  assign b1    = left_justify_i ? 7'd0 : sc;
  assign b2    = b1 + {6'd0, sign_flag_i};
  assign b3    = b2 + zc;
  assign b4    = b3 + {2'b00, len};
  assign total = b4 + (left_justify_i ? sc : 7'd0);

  assign desc_o.value = value_i;
  assign desc_o.b1    = b1;
  assign desc_o.b2    = b2;
  assign desc_o.b3    = b3;
  assign desc_o.b4    = b4;
  assign desc_o.total = total;
  assign nonempty_o   = (total != 7'd0);

endmodule

`default_nettype wire

### rtl/core/hxf_back.sv
// Back of the formatter: walks one descriptor and emits one character per cycle unless out_full_i.
// Depends on hxf_pkg.
`default_nettype none

module hxf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hxf_pkg::desc_t desc_i,
  input  wire logic           desc_valid_i,
  output logic                desc_pop_o,
  input  wire logic           out_full_i,
  output logic                out_push_o,
  output hxf_pkg::char_t      out_o
);

  logic [hxf_pkg::PosW-1:0] pos_q, pos_d;
  logic [hxf_pkg::PosW-1:0] kfull;
  logic [3:0]               k;
  logic                     last;

  assign out_push_o = desc_valid_i && !out_full_i;
  assign last       = (pos_q == desc_i.total - 7'd1);
  assign desc_pop_o = out_push_o && last;
  assign kfull      = desc_i.b4 - 7'd1 - pos_q;
  assign k          = kfull[3:0];

  always_comb begin
    if (pos_q < desc_i.b1) begin
      out_o.ch = hxf_pkg::CharSpace;
    end else if (pos_q < desc_i.b2) begin
      out_o.ch = hxf_pkg::CharMinus;
    end else if (pos_q < desc_i.b3) begin
      out_o.ch = hxf_pkg::CharZero;
    end else if (pos_q < desc_i.b4) begin
      out_o.ch = hxf_pkg::hex_char(desc_i.value[4*k +: 4]);
    end else begin
      out_o.ch = hxf_pkg::CharSpace;
    end
    out_o.last = last;
  end

  always_comb begin
    pos_d = pos_q;
    if (desc_pop_o) begin
      pos_d = '0;
    end else if (out_push_o) begin
      pos_d = pos_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hex_upper_field_formatter.sv
// Top level of the uppercase hex field formatter (printf %X style).
// Depends on hxf_pkg, hxf_front, hxf_fifo and hxf_back.
//
//   channel  direction  handshake          payload
//   input    in         push / full        value, field_width, precision, flags
//   result   out        pop / empty        char_out, last_char
//
// The front classifies a word in the cycle it is accepted and queues a layout
// descriptor; a new word is taken every cycle while the two-entry queue has room.
// The back emits one character per cycle while the result buffer has room; a field
// has at most MAX_FIELD + 1 characters if MAX_FIELD >= 16, and a word that prints
// nothing is accepted but queues no descriptor. Reset empties both queues. A stalled
// result side fills the result buffer, then the descriptor queue, then raises full.
`default_nettype none

module hex_upper_field_formatter #(
  parameter int unsigned MAX_FIELD = 40
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [63:0]       value_i,
  input  wire logic [5:0]        field_width_i,
  input  wire logic signed [6:0] precision_i,
  input  wire logic              left_justify_i,
  input  wire logic              zero_pad_i,
  input  wire logic              sign_flag_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [6:0]             char_out_o,
  output logic                   last_char_o
);

  localparam int unsigned QueueDepth = 2;

  hxf_pkg::desc_t front_desc, head_desc;
  hxf_pkg::char_t back_char, res_char;
  logic           nonempty, desc_push, desc_empty, desc_pop;
  logic           out_full, out_push;

  hxf_front #(
    .MaxField(MAX_FIELD)
  ) u_front (
    .value_i       (value_i),
    .field_width_i (field_width_i),
    .precision_i   (precision_i),
    .left_justify_i(left_justify_i),
    .zero_pad_i    (zero_pad_i),
    .sign_flag_i   (sign_flag_i),
    .desc_o        (front_desc),
    .nonempty_o    (nonempty)
  );

  assign desc_push = push && !full && nonempty;

  hxf_fifo #(
    .Width($bits(hxf_pkg::desc_t)),
    .Depth(QueueDepth)
  ) u_desc_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (desc_push),
    .data_i (front_desc),
    .full_o (full),
    .pop_i  (desc_pop),
    .data_o (head_desc),
    .empty_o(desc_empty)
  );

  hxf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (head_desc),
    .desc_valid_i(!desc_empty),
    .desc_pop_o  (desc_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_o       (back_char)
  );

  hxf_fifo #(
    .Width($bits(hxf_pkg::char_t)),
    .Depth(QueueDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (back_char),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (res_char),
    .empty_o(empty)
  );

  assign char_out_o  = res_char.ch;
  assign last_char_o = res_char.last;

`ifndef SYNTHESIS
  a_desc_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_push |=> !desc_empty)
    else $error("Accepted field left no descriptor in the queue.");

  a_done_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop |-> (out_push && back_char.last))
    else $error("Descriptor retired without a final character.");

  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (char_out_o == hxf_pkg::CharSpace || char_out_o == hxf_pkg::CharMinus ||
                (char_out_o >= 7'h30 && char_out_o <= 7'h39) ||
                (char_out_o >= 7'h41 && char_out_o <= 7'h46)))
    else $error("Result character outside the field alphabet.");
`endif

endmodule

`default_nettype wire

### sim/hex_upper_field_formatter_tb.sv
// Self-checking testbench for hex_upper_field_formatter, the printf %X field formatter.
// Drives a table of directed fields and then random ones, with bursty push and stalled pop.
// Depends on hxf_pkg and the formatter RTL.
`timescale 1ns / 100ps

module hex_upper_field_formatter_tb;

  localparam int MaxField = 40;
  localparam int NumDirected = 24;
  localparam int NumRandom = 300;
  localparam int MaxReports = 50;

  typedef struct packed {
    logic [63:0]       value;
    logic [5:0]        fw;
    logic signed [6:0] prec;
    logic              lj;
    logic              zp;
    logic              sg;
  } hex_req_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [63:0]       value_i = '0;
  logic [5:0]        field_width_i = '0;
  logic signed [6:0] precision_i = '0;
  logic              left_justify_i = 1'b0;
  logic              zero_pad_i = 1'b0;
  logic              sign_flag_i = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [6:0]        char_out_o;
  logic              last_char_o;

  hxf_pkg::char_t expected_chars[$];
  int    mismatches = 0;
  int    burst_left = 0;

  // A text of "*" means the row is checked against the predictor.
  hex_req_t dir_reqs [NumDirected] = '{
    '{64'h0, 6'd0, -7'sd1, 1'b0, 1'b0, 1'b0},
    '{64'h0, 6'd0, 7'sd0, 1'b0, 1'b0, 1'b0},
    '{64'h0, 6'd5, 7'sd0, 1'b0, 1'b0, 1'b0},
    '{64'h0, 6'd3, 7'sd0, 1'b1, 1'b0, 1'b1},
    '{64'h0, 6'd8, -7'sd1, 1'b0, 1'b1, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'd0, -7'sd1, 1'b0, 1'b0, 1'b0},
    '{64'h0123_4567_89AB_CDEF, 6'd0, -7'sd1, 1'b0, 1'b0, 1'b0},
    '{64'hFEDC_BA98_7654_3210, 6'd0, 7'sd20, 1'b0, 1'b0, 1'b0},
    '{64'h1234_ABCD, 6'd12, -7'sd1, 1'b0, 1'b0, 1'b0},
    '{64'h1234_ABCD, 6'd12, -7'sd1, 1'b1, 1'b0, 1'b0},
    '{64'hAB, 6'd6, -7'sd1, 1'b0, 1'b1, 1'b0},
    '{64'hAB, 6'd6, -7'sd1, 1'b1, 1'b1, 1'b0},
    '{64'hAB, 6'd6, 7'sd4, 1'b0, 1'b1, 1'b0},
    '{64'hAB, 6'd6, -7'sd1, 1'b0, 1'b0, 1'b1},
    '{64'hAB, 6'd6, -7'sd1, 1'b0, 1'b1, 1'b1},
    '{64'hAB, 6'd6, -7'sd1, 1'b1, 1'b0, 1'b1},
    '{64'hFFFF, 6'd2, -7'sd1, 1'b0, 1'b1, 1'b0},
    '{64'h3, 6'd4, -7'sd64, 1'b0, 1'b1, 1'b0},
    '{64'hC, 6'd3, -7'sd2, 1'b0, 1'b0, 1'b0},
    '{64'h1, 6'd63, -7'sd1, 1'b0, 1'b0, 1'b0},
    '{64'h5, 6'd0, 7'sd63, 1'b0, 1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 7'sd63, 1'b0, 1'b0, 1'b1},
    '{64'h0, 6'd63, -7'sd1, 1'b1, 1'b1, 1'b1},
    '{64'h9, 6'd40, 7'sd40, 1'b1, 1'b0, 1'b0}
  };

  string dir_text [NumDirected] = '{
    "0", "", "     ", "-   ", "00000000", "FFFFFFFFFFFFFFFF", "123456789ABCDEF",
    "0000FEDCBA9876543210", "    1234ABCD", "1234ABCD    ", "0000AB", "AB    ",
    "  00AB", "    -AB", "-0000AB", "-AB    ", "FFFF", "0003", "  C",
    "*", "*", "*", "*", "*"
  };

  hex_upper_field_formatter #(
    .MAX_FIELD(MaxField)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .value_i       (value_i),
    .field_width_i (field_width_i),
    .precision_i   (precision_i),
    .left_justify_i(left_justify_i),
    .zero_pad_i    (zero_pad_i),
    .sign_flag_i   (sign_flag_i),
    .empty         (empty),
    .pop           (pop),
    .char_out_o    (char_out_o),
    .last_char_o   (last_char_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxReports) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic void add_run(ref hxf_pkg::char_t f[$], input int n,
                                  input logic [6:0] c);
    for (int k = 0; k < n; k++) begin
      f.push_back('{ch: c, last: 1'b0});
    end
  endfunction

  function automatic void queue_field(input hxf_pkg::char_t f[$]);
    if (f.size() > 0) begin
      f[f.size() - 1].last = 1'b1;
    end
    foreach (f[i]) begin
      expected_chars.push_back(f[i]);
    end
  endfunction

  function automatic void expect_text(input string s);
    hxf_pkg::char_t f[$];
    byte   b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      f.push_back('{ch: b[6:0], last: 1'b0});
    end
    queue_field(f);
  endfunction

  function automatic void predict_hex_field(input hex_req_t r);
    hxf_pkg::char_t f[$];
    string       glyphs;
    byte         b;
    int          width, prec, len, zeros, spaces;
    bit          has_prec;
    logic [63:0] t;
    glyphs = "0123456789ABCDEF";
    width = (int'(r.fw) > MaxField) ? MaxField : int'(r.fw);
    prec = int'(r.prec);
    has_prec = (prec >= 0);
    if (prec > MaxField) begin
      prec = MaxField;
    end
    len = 1;
    t = r.value;
    while (t > 64'd15) begin
      t = t >> 4;
      len++;
    end
    if (has_prec && prec == 0 && r.value == 64'd0) begin
      len = 0;
    end
    zeros = 0;
    if (r.zp && !r.lj && !has_prec) begin
      zeros = width - len;
    end
    if (has_prec && len < prec) begin
      zeros = prec - len;
    end
    spaces = width - len - zeros;
    if (!r.lj) begin
      add_run(f, spaces, hxf_pkg::CharSpace);
    end
    if (r.sg) begin
      add_run(f, 1, hxf_pkg::CharMinus);
    end
    add_run(f, zeros, hxf_pkg::CharZero);
    for (int k = len - 1; k >= 0; k--) begin
      b = glyphs[r.value[4*k +: 4]];
      add_run(f, 1, b[6:0]);
    end
    if (r.lj) begin
      add_run(f, spaces, hxf_pkg::CharSpace);
    end
    queue_field(f);
  endfunction

  function automatic hex_req_t random_req();
    hex_req_t    r;
    int          n;
    logic [63:0] raw;
    n = $urandom_range(0, 16);
    raw = {$urandom, $urandom};
    r.value = (n == 0) ? 64'd0 : raw >> (4 * (16 - n));
    case ($urandom_range(0, 9))
      0: r.fw = 6'($urandom_range(41, 63));
      1: r.fw = 6'($urandom_range(21, 40));
      default: r.fw = 6'($urandom_range(0, 20));
    endcase
    case ($urandom_range(0, 9))
      0, 1: r.prec = -7'sd1;
      2: r.prec = 7'($urandom_range(64, 126));
      3: r.prec = 7'sd0;
      4: r.prec = 7'($urandom_range(21, 63));
      default: r.prec = 7'($urandom_range(1, 20));
    endcase
    r.lj = 1'($urandom);
    r.zp = 1'($urandom);
    r.sg = 1'($urandom);
    return r;
  endfunction

  task automatic send_word(input hex_req_t r, input string text);
    int gap;
    value_i <= r.value;
    field_width_i <= r.fw;
    precision_i <= r.prec;
    left_justify_i <= r.lj;
    zero_pad_i <= r.zp;
    sign_flag_i <= r.sg;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    if (text == "*") begin
      predict_hex_field(r);
    end else begin
      expect_text(text);
    end
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumDirected; i++) begin
      send_word(dir_reqs[i], dir_text[i]);
    end
    for (int i = 0; i < NumRandom; i++) begin
      send_word(random_req(), "*");
    end
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin : drain
    hxf_pkg::char_t want;
    logic    next_pop;
    int      mode;
    int      cycle;
    int      hold;
    if (!rst_ni) begin
      pop <= 1'b0;
      mode = 0;
      cycle = 0;
      hold = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("word %h with no field pending", char_out_o));
        end else begin
          want = expected_chars.pop_front();
          if (char_out_o !== want.ch) begin
            report_mismatch($sformatf("char_out %h, want %h", char_out_o, want.ch));
          end
          if (last_char_o !== want.last) begin
            report_mismatch($sformatf("last_char %b, want %b", last_char_o, want.last));
          end
        end
      end
      cycle++;
      if (cycle % 97 == 0) begin
        mode = $urandom_range(0, 3);
      end
      case (mode)
        0: next_pop = 1'b1;
        1: next_pop = 1'($urandom);
        2: next_pop = (cycle % 3 == 0);
        default: begin
          if (hold > 0) begin
            hold--;
            next_pop = 1'b0;
          end else begin
            hold = $urandom_range(5, 25);
            next_pop = 1'b1;
          end
        end
      endcase
      pop <= next_pop;
    end
  end

endmodule

### sim.f
rtl/core/hxf_pkg.sv
rtl/core/hxf_fifo.sv
rtl/core/hxf_front.sv
rtl/core/hxf_back.sv
rtl/core/hex_upper_field_formatter.sv
sim/hex_upper_field_formatter_tb.sv
